/* rtl/core/sha1_pkg.sv */
// Shared types, constants and round functions for the SHA-1 digest engine.
package sha1_pkg;

    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned NUM_ROUNDS  = 80;
    localparam int unsigned NUM_DIGEST  = 5;

    localparam logic [6:0] ROUND_LAST   = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] WORD_LAST    = 3'(NUM_DIGEST - 1);
    localparam logic [5:0] POS_LAST     = 6'd63;
    localparam logic [2:0] LEN_ROW      = 3'd7;  // bytes 56..63 of a block
    localparam logic [7:0] PAD_MARK     = 8'h80;

    localparam logic [31:0] H_INIT [NUM_DIGEST] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } st_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_BYTE,
        SH_WORD
    } shift_mode_t;

    typedef struct packed {
        shift_mode_t mode;
        logic [7:0]  byte_in;
    } row_ctrl_t;

    // Round group from the round number: 0..19, 20..39, 40..59, 60..79.
    function automatic logic [1:0] round_phase(input logic [6:0] rnd);
        logic [1:0] ph;
        if (rnd < 7'd20) begin
            ph = 2'd0;
        end else if (rnd < 7'd40) begin
            ph = 2'd1;
        end else if (rnd < 7'd60) begin
            ph = 2'd2;
        end else begin
            ph = 2'd3;
        end
        return ph;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] ph,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (ph)
            2'd0:    f = (b & (c ^ d)) ^ d;
            2'd2:    f = (b & c) | ((b | c) & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

/* rtl/core/sha1_wcell.sv */
// One cell of the block buffer: holds a word, shifts by byte or by word from its neighbor.
module sha1_wcell
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  shift_mode_t mode,
    input  logic [31:0] nb_word,
    output logic [31:0] word_out
);

    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb begin
        case (mode)
            SH_BYTE: word_next = {word_reg[23:0], nb_word[31:24]};
            SH_WORD: word_next = nb_word;
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

/* rtl/core/sha1_wrow.sv */
// Row of sixteen buffer cells: byte-wise block fill and the rolling message schedule.
module sha1_wrow
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  row_ctrl_t   ctrl,
    output logic [31:0] w_out
);

    logic [31:0] cell_word [NUM_WORDS];
    logic [31:0] nb_word   [NUM_WORDS];
    logic [31:0] sched_mix;
    logic [31:0] tail_word;

    // W[t] = rotl1(W[t-3] ^ W[t-8] ^ W[t-14] ^ W[t-16]); cell 0 holds W[t-16]
    assign sched_mix = cell_word[13] ^ cell_word[8] ^ cell_word[2] ^ cell_word[0];
    assign tail_word = (ctrl.mode == SH_BYTE) ? {ctrl.byte_in, 24'h000000}
                                              : {sched_mix[30:0], sched_mix[31]};

    genvar gi;
    generate
        for (gi = 0; gi < NUM_WORDS; gi++) begin : g_cell
            if (gi == NUM_WORDS - 1) begin : g_tail
                assign nb_word[gi] = tail_word;
            end else begin : g_body
                assign nb_word[gi] = cell_word[gi + 1];
            end

            sha1_wcell u_cell (
                .aclk     (aclk),
                .mode     (ctrl.mode),
                .nb_word  (nb_word[gi]),
                .word_out (cell_word[gi])
            );
        end
    endgenerate

    assign w_out = cell_word[0];

endmodule

/* rtl/core/sha1_message_digest_top.sv */
// SHA-1 digest engine top level: byte intake, padding, round unit and digest output.
//
// Input channel s_*: one message byte per transfer. s_tdata carries the byte,
// s_tuser marks it as part of the message, s_tlast ends the message (with or
// without a byte). A transfer with neither flag set changes nothing.
// Output channel m_*: five transfers per message, digest words h0..h4, with
// the word number on m_tuser and m_tlast on h4.
// Bytes are taken one per cycle while idle. The byte that fills a 64-byte
// block is followed by a busy period: 80 rounds through the single round unit,
// one per cycle, fed by the sixteen-cell schedule row, then a step adding into
// the chaining value. After the end transfer the engine inserts 9 to 72
// padding bytes at one per cycle, runs one or two compressions, then offers
// the digest.
// s_tready is low while padding, compressing or presenting the digest; the
// engine takes one message at a time. A stalled receiver holds the current
// digest word on m_tdata until taken. After the h4 transfer the chaining
// value and length return to their initial values.
// Reset (aresetn low, synchronous) loads the initial chaining value, clears
// the length and returns to intake; the block buffer needs no clearing.
module sha1_message_digest_top
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    st_t         state_reg, state_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [63:0] msg_len_reg, msg_len_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] chain_reg  [NUM_DIGEST];
    logic [31:0] chain_next [NUM_DIGEST];
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_mark_reg, pad_mark_next;
    logic        len_ok_reg, len_ok_next;
    logic        fin_reg, fin_next;
    logic        pad_act_reg, pad_act_next;

    row_ctrl_t   row_ctrl;
    logic [31:0] w_cur;
    logic [5:0]  pos;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    logic        is_len;
    logic [1:0]  phase;
    logic [31:0] rnd_sum;
    logic        s_xfer;
    logic        m_xfer;

    sha1_wrow u_row (
        .aclk  (aclk),
        .ctrl  (row_ctrl),
        .w_out (w_cur)
    );

    assign pos      = bit_len_reg[8:3];
    assign len_sel  = ~pos[2:0];
    assign len_byte = msg_len_reg[{len_sel, 3'b000} +: 8];
    assign is_len   = !pad_mark_reg && len_ok_reg && (pos[5:3] == LEN_ROW);

    assign phase   = round_phase(rnd_reg);
    assign rnd_sum = {a_reg[26:0], a_reg[31:27]} + round_f(phase, b_reg, c_reg, d_reg)
                   + e_reg + K_ROUND[phase] + w_cur;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_xfer   = m_tvalid && m_tready;
    assign m_tdata  = chain_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == WORD_LAST);

    always_comb begin
        state_next    = state_reg;
        bit_len_next  = bit_len_reg;
        msg_len_next  = msg_len_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        chain_next    = chain_reg;
        rnd_next      = rnd_reg;
        out_idx_next  = out_idx_reg;
        pad_mark_next = pad_mark_reg;
        len_ok_next   = len_ok_reg;
        fin_next      = fin_reg;
        pad_act_next  = pad_act_reg;
        row_ctrl      = '{mode: SH_HOLD, byte_in: 8'h00};

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser) begin
                        row_ctrl     = '{mode: SH_BYTE, byte_in: s_tdata};
                        bit_len_next = bit_len_reg + 64'd8;
                    end
                    if (s_tlast) begin
                        msg_len_next  = bit_len_next;
                        pad_mark_next = 1'b1;
                        len_ok_next   = 1'b0;
                        pad_act_next  = 1'b1;
                        state_next    = ST_PAD;
                    end
                    // a full block goes to the rounds first, padding resumes after
                    if (s_tuser && pos == POS_LAST) begin
                        state_next = ST_ROUND;
                    end
                end
            end

            ST_PAD: begin
                bit_len_next  = bit_len_reg + 64'd8;
                pad_mark_next = 1'b0;
                if (pad_mark_reg) begin
                    row_ctrl = '{mode: SH_BYTE, byte_in: PAD_MARK};
                    if (pos[5:3] != LEN_ROW) begin
                        len_ok_next = 1'b1;
                    end
                end else if (is_len) begin
                    row_ctrl = '{mode: SH_BYTE, byte_in: len_byte};
                end else begin
                    row_ctrl = '{mode: SH_BYTE, byte_in: 8'h00};
                end
                if (pos == POS_LAST) begin
                    fin_next    = is_len;
                    len_ok_next = 1'b1;
                    state_next  = ST_ROUND;
                end
            end

            ST_ROUND: begin
                row_ctrl = '{mode: SH_WORD, byte_in: 8'h00};
                a_next   = rnd_sum;
                b_next   = a_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                d_next   = c_reg;
                e_next   = d_reg;
                if (rnd_reg == ROUND_LAST) begin
                    rnd_next   = 7'd0;
                    state_next = ST_FINAL;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end

            ST_FINAL: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                if (fin_reg) begin
                    out_idx_next = 3'd0;
                    state_next   = ST_OUT;
                end else if (pad_act_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT: begin
                if (m_xfer) begin
                    if (out_idx_reg == WORD_LAST) begin
                        chain_next   = H_INIT;
                        bit_len_next = 64'd0;
                        fin_next     = 1'b0;
                        pad_act_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // load the working variables from the chaining value as a block completes
        if (state_next == ST_ROUND && state_reg != ST_ROUND) begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_len_reg  <= 64'd0;
            chain_reg    <= H_INIT;
            rnd_reg      <= 7'd0;
            out_idx_reg  <= 3'd0;
            pad_mark_reg <= 1'b0;
            len_ok_reg   <= 1'b0;
            fin_reg      <= 1'b0;
            pad_act_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_len_reg  <= bit_len_next;
            chain_reg    <= chain_next;
            rnd_reg      <= rnd_next;
            out_idx_reg  <= out_idx_next;
            pad_mark_reg <= pad_mark_next;
            len_ok_reg   <= len_ok_next;
            fin_reg      <= fin_next;
            pad_act_reg  <= pad_act_next;
        end
    end

    always_ff @(posedge aclk) begin
        msg_len_reg <= msg_len_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
    end

    a_round_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (rnd_reg <= ROUND_LAST))
        else $error("round counter out of range");

    a_round_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_ROUND) |-> (rnd_reg == 7'd0))
        else $error("compression started at a nonzero round");

    a_round_to_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == ROUND_LAST) |=> (state_reg == ST_FINAL))
        else $error("last round not followed by the chaining update");

    a_digest_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (s_tready && bit_len_reg == 64'd0))
        else $error("engine not reinitialized after the digest");

    a_byte_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (bit_len_reg[2:0] == 3'd0) && !(s_tready && m_tvalid))
        else $error("bit length misaligned or both channels active");

endmodule
